/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros for the uudecode stream design
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define UUD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define UUD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/uud_pkg.sv */
// ----------------------------------------------------------------------------
// uud_pkg
// constants and shared types of the little-endian uudecode stream block
// ----------------------------------------------------------------------------
package uud_pkg;

    localparam int POS_W = 7;
    localparam int CNT_W = 6;
    localparam int ACC_W = 24;

    localparam logic [POS_W-1:0] MAX_LINE_CHARS = 7'd126;
    localparam logic [7:0]       MAX_LINE_BYTES = 8'd45;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_HIGH    = 8'd96;

    // bit positions inside m_tuser
    localparam int TUSER_BYTE_VALID = 0;
    localparam int TUSER_LINE_ERROR = 1;
    localparam int TUSER_TEXT_DONE  = 2;
    localparam int TUSER_W          = 3;

    // one result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       line_error;
        logic       text_done;
        logic       run_last;
    } uud_result_t;

    // engine handshake toward the top level
    typedef struct packed {
        logic emit;     // result goes into the output register this cycle
        logic consume;  // held character is finished this cycle
    } uud_ctl_t;

endpackage

/* design/uud_engine.sv */
// ----------------------------------------------------------------------------
// uud_engine
// line and group state of the decoder; while the output register is free, one result per cycle from the held item
// ----------------------------------------------------------------------------
module uud_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  logic [7:0]           item_char,
    input  logic                 item_eot,
    input  logic                 out_free,
    output uud_pkg::uud_result_t res,
    output uud_pkg::uud_ctl_t    ctl
);
    import uud_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             active_reg, active_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [1:0]       idx_reg, idx_next;
    logic             broken_reg, broken_next;
    logic [CNT_W-1:0] emitted_reg, emitted_next;
    logic             err_reg, err_next;
    logic             drain_reg, drain_next;
    logic [CNT_W-1:0] left_reg, left_next;

    logic             char_ok;
    logic [5:0]       digit;
    logic [ACC_W-1:0] digit_shifted;
    logic [ACC_W-1:0] acc_new;
    logic             is_nl;
    logic             line_end;
    logic             too_long;
    logic             first_char;
    logic             data_char;
    logic             group_fin;
    logic             count_ok;
    logic [CNT_W-1:0] left_now;
    logic [CNT_W-1:0] k;
    logic             has_result;
    logic             last;
    logic             step;

    // character classification
    always_comb begin
        char_ok    = (item_char >= CHAR_SPACE) && (item_char <= CHAR_HIGH);
        digit      = 6'(item_char - CHAR_SPACE);
        count_ok   = (item_char > CHAR_SPACE) && (item_char <= (CHAR_SPACE + MAX_LINE_BYTES));
        is_nl      = (item_char == CHAR_NEWLINE);
        line_end   = item_eot ? (!err_reg && pos_reg != '0) : (!err_reg && is_nl);
        too_long   = !item_eot && !err_reg && !is_nl && (pos_reg >= MAX_LINE_CHARS);
        first_char = !item_eot && !err_reg && !is_nl && !too_long && (pos_reg == '0);
        data_char  = !item_eot && !err_reg && !is_nl && !too_long && (pos_reg != '0);
    end

    // digit placement, first digit in the low bits; only data characters add a digit
    always_comb begin
        case (idx_reg)
            2'd0:    digit_shifted = {18'd0, digit};
            2'd1:    digit_shifted = {12'd0, digit, 6'd0};
            2'd2:    digit_shifted = {6'd0, digit, 12'd0};
            default: digit_shifted = {digit, 18'd0};
        endcase
        acc_new = (data_char && active_reg && !broken_reg && char_ok)
                ? (acc_reg | digit_shifted) : acc_reg;
    end

    // number of bytes this item emits
    always_comb begin
        left_now  = count_reg - emitted_reg;
        group_fin = data_char && active_reg && (idx_reg == 2'd3);
        if (line_end) begin
            k = active_reg ? left_now : '0;
        end else if (group_fin) begin
            k = (left_now > 6'd3) ? 6'd3 : left_now;
        end else begin
            k = '0;
        end
    end

    // result and handshake
    always_comb begin
        if (drain_reg) begin
            has_result     = 1'b1;
            last           = (left_reg == 6'd1);
            res.out_byte   = acc_reg[7:0];
            res.byte_valid = 1'b1;
            res.line_error = err_reg;
            res.text_done  = item_eot && last;
            res.run_last   = last;
        end else if (k != '0) begin
            has_result     = 1'b1;
            last           = (k == 6'd1);
            res.out_byte   = acc_new[7:0];
            res.byte_valid = 1'b1;
            res.line_error = err_reg;
            res.text_done  = item_eot && last;
            res.run_last   = last;
        end else begin
            has_result     = item_eot || too_long;
            last           = 1'b1;
            res.out_byte   = 8'd0;
            res.byte_valid = 1'b0;
            res.line_error = err_reg || too_long;
            res.text_done  = item_eot;
            res.run_last   = 1'b1;
        end
        step        = item_valid && (!has_result || out_free);
        ctl.emit    = step && has_result;
        ctl.consume = step && last;
    end

    // next state
    always_comb begin
        pos_next     = pos_reg;
        count_next   = count_reg;
        active_next  = active_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        broken_next  = broken_reg;
        emitted_next = emitted_reg;
        err_next     = err_reg;
        drain_next   = drain_reg;
        left_next    = left_reg;

        if (step) begin
            if (drain_reg) begin
                // one more byte of a multi-byte run
                acc_next     = acc_reg >> 8;
                emitted_next = emitted_reg + 6'd1;
                left_next    = left_reg - 6'd1;
                if (last) begin
                    drain_next = 1'b0;
                    acc_next   = '0;
                    idx_next   = '0;
                    broken_next = 1'b0;
                    if (item_eot || is_nl) begin
                        pos_next     = '0;
                        count_next   = '0;
                        active_next  = 1'b0;
                        emitted_next = '0;
                    end
                    if (item_eot) begin
                        err_next = 1'b0;
                    end
                end
            end else if (k > 6'd1) begin
                // start of a run of bytes
                if (data_char) begin
                    pos_next    = pos_reg + 7'd1;
                    broken_next = broken_reg | !char_ok;
                end
                acc_next     = acc_new >> 8;
                emitted_next = emitted_reg + 6'd1;
                drain_next   = 1'b1;
                left_next    = k - 6'd1;
            end else if (item_eot || (line_end && !err_reg)) begin
                // line end with at most one byte, or end of text
                pos_next     = '0;
                count_next   = '0;
                active_next  = 1'b0;
                acc_next     = '0;
                idx_next     = '0;
                broken_next  = 1'b0;
                emitted_next = '0;
                if (item_eot) begin
                    err_next = 1'b0;
                end
            end else if (too_long) begin
                err_next = 1'b1;
            end else if (first_char) begin
                pos_next     = 7'd1;
                active_next  = count_ok;
                count_next   = count_ok ? 6'(item_char - CHAR_SPACE) : '0;
                emitted_next = '0;
                acc_next     = '0;
                idx_next     = '0;
                broken_next  = 1'b0;
            end else if (data_char) begin
                pos_next = pos_reg + 7'd1;
                if (active_reg) begin
                    if (group_fin) begin
                        emitted_next = emitted_reg + k;
                        acc_next     = '0;
                        idx_next     = '0;
                        broken_next  = 1'b0;
                    end else begin
                        acc_next    = acc_new;
                        broken_next = broken_reg | !char_ok;
                        idx_next    = idx_reg + 2'd1;
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            count_reg   <= '0;
            active_reg  <= 1'b0;
            acc_reg     <= '0;
            idx_reg     <= '0;
            broken_reg  <= 1'b0;
            emitted_reg <= '0;
            err_reg     <= 1'b0;
            drain_reg   <= 1'b0;
            left_reg    <= '0;
        end else begin
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            active_reg  <= active_next;
            acc_reg     <= acc_next;
            idx_reg     <= idx_next;
            broken_reg  <= broken_next;
            emitted_reg <= emitted_next;
            err_reg     <= err_next;
            drain_reg   <= drain_next;
            left_reg    <= left_next;
        end
    end

endmodule

/* design/uudecode_stream_top.sv */
// ----------------------------------------------------------------------------
// uudecode_stream_top
// little-endian uudecoder, one text character in, decoded bytes out
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tdata[7:0] character, tlast end of text
//  m_*       out        tdata[7:0] byte, tuser byte_valid/line_error/text_done,
//                       tlast last result of the character
//
//  a character is taken every cycle when it gives at most one result and the output register is free
//  a character closing a group gives up to 3 bytes, a newline or end of text
//  up to the line's byte count (at most 45), one byte per cycle while the output is free, through the
//  single output register
//  synchronous active-low reset; no clearing pass, the block is ready at once
//  input and output registers hold the data; m_tready reaches s_tready combinationally, no skid register on either side
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uudecode_stream_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_char
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [0] byte_valid, [1] line_error, [2] text_done
    output logic       m_tlast    // run_last
);
    import uud_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_char_reg, in_char_next;
    logic        in_eot_reg, in_eot_next;
    logic        out_valid_reg, out_valid_next;
    uud_result_t out_reg, out_next;
    uud_result_t res;
    uud_ctl_t    ctl;
    logic        out_free;

    // input register
    assign s_tready = !in_valid_reg || ctl.consume;
    always_comb begin
        in_valid_next = in_valid_reg;
        in_char_next  = in_char_reg;
        in_eot_next   = in_eot_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_char_next  = s_tdata;
            in_eot_next   = s_tlast;
        end
    end

    uud_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item_char  (in_char_reg),
        .item_eot   (in_eot_reg),
        .out_free   (out_free),
        .res        (res),
        .ctl        (ctl)
    );

    // output register
    assign out_free = !out_valid_reg || m_tready;
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free) begin
            out_valid_next = ctl.emit;
        end
        if (ctl.emit) begin
            out_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_char_reg <= in_char_next;
        in_eot_reg  <= in_eot_next;
        out_reg     <= out_next;
    end

    // output ports
    assign m_tvalid                  = out_valid_reg;
    assign m_tdata                   = out_reg.out_byte;
    assign m_tuser[TUSER_BYTE_VALID] = out_reg.byte_valid;
    assign m_tuser[TUSER_LINE_ERROR] = out_reg.line_error;
    assign m_tuser[TUSER_TEXT_DONE]  = out_reg.text_done;
    assign m_tlast                   = out_reg.run_last;

    // checks
    `UUD_ASSERT(a_emit_has_item, aclk, aresetn, !ctl.emit || in_valid_reg, "result without held character")
    `UUD_ASSERT(a_done_is_last, aclk, aresetn, !(m_tvalid && m_tuser[TUSER_TEXT_DONE]) || m_tlast, "text_done without tlast")
    `UUD_ASSERT(a_invalid_zero, aclk, aresetn, !(m_tvalid && !m_tuser[TUSER_BYTE_VALID]) || (m_tdata == 8'd0), "nonzero byte without byte_valid")
    `UUD_ASSERT_NEXT(a_emit_loads, aclk, aresetn, ctl.emit, m_tvalid, "emitted result not presented")

endmodule

/* test/tb_uudecode_stream_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uudecode_stream_top
// self-checking testbench for the little-endian uudecode stream block
// ----------------------------------------------------------------------------
//  text characters are queued by an initial block and driven one transaction
//  at a time; every accepted character runs through a local decoder model that
//  appends the result transactions it should cause to a queue, and each
//  output transaction is compared field by field with the oldest entry
//  a short directed text covers the count extremes, invalid digits, short and
//  overfull lines, skipped lines, overlong lines and end of text; random texts
//  follow under three idling patterns on the two channels
// ----------------------------------------------------------------------------
module tb_uudecode_stream_top;
    import uud_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 64;
    localparam int PHASE_CHARS    = 24;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } text_item_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;   // [7:0] text_char
    logic       s_tlast  = 1'b0;   // end_of_text
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic [2:0] m_tuser;           // [0] byte_valid, [1] line_error, [2] text_done
    logic       m_tlast;           // run_last

    // stimulus and checking bookkeeping
    text_item_t  pending_chars[$];
    uud_result_t decoded_q[$];
    text_item_t  next_char;
    int chars_offered   = 0;
    int chars_taken     = 0;
    int chars_queued    = 0;
    int bytes_checked   = 0;
    int texts_queued    = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;
    int send_idle_pct   = 37;
    int recv_idle_pct   = 88;

    // decoder model state
    logic [POS_W-1:0] line_pos      = '0;
    logic [CNT_W-1:0] line_count    = '0;
    logic [CNT_W-1:0] line_sent     = '0;
    logic             line_is_data  = 1'b0;
    logic [ACC_W-1:0] group_bits    = '0;
    logic [1:0]       group_slot    = '0;
    logic             group_bad     = 1'b0;
    logic             overlong_seen = 1'b0;
    int               step_results  = 0;

    uudecode_stream_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------

    task automatic push_result(input logic [7:0] b, input logic valid);
        uud_result_t r;
        r.out_byte   = b;
        r.byte_valid = valid;
        r.line_error = overlong_seen;
        r.text_done  = 1'b0;
        r.run_last   = 1'b0;
        decoded_q.push_back(r);
        step_results++;
    endtask

    // one decoded byte, dropped at the line count or the per-character byte limit
    task automatic emit_decoded(input logic [7:0] b);
        if (line_sent < line_count && step_results < MAX_LINE_BYTES) begin
            push_result(b, 1'b1);
            line_sent++;
        end
    endtask

    task automatic drain_group();
        for (int j = 0; j < 3; j++)
            emit_decoded(group_bits[8*j +: 8]);
        group_bits = '0;
        group_slot = '0;
        group_bad  = 1'b0;
    endtask

    task automatic clear_line();
        line_pos     = '0;
        line_count   = '0;
        line_sent    = '0;
        line_is_data = 1'b0;
        group_bits   = '0;
        group_slot   = '0;
        group_bad    = 1'b0;
    endtask

    // flush a partial group, then pad missing bytes with zeros
    task automatic close_line();
        if (line_is_data) begin
            if (group_slot != 0)
                drain_group();
            while (line_sent < line_count && step_results < MAX_LINE_BYTES)
                emit_decoded(8'd0);
        end
        clear_line();
    endtask

    // expected transactions for one accepted character
    task automatic decode_char(input logic [7:0] ch, input logic eot);
        uud_result_t last_r;
        step_results = 0;
        if (eot) begin
            if (!overlong_seen && line_pos != 0)
                close_line();
            if (step_results == 0)
                push_result(8'd0, 1'b0);
            last_r = decoded_q[decoded_q.size()-1];
            last_r.text_done = 1'b1;
            last_r.run_last  = 1'b1;
            decoded_q[decoded_q.size()-1] = last_r;
            clear_line();
            overlong_seen = 1'b0;
        end else if (!overlong_seen) begin
            if (ch == CHAR_NEWLINE) begin
                close_line();
            end else if (line_pos >= MAX_LINE_CHARS) begin
                overlong_seen = 1'b1;
                push_result(8'd0, 1'b0);
            end else if (line_pos == 0) begin
                // count character decides whether the line carries data
                clear_line();
                line_pos     = 1;
                line_is_data = (ch >= CHAR_SPACE + 8'd1) && (ch <= CHAR_SPACE + MAX_LINE_BYTES);
                line_count   = line_is_data ? CNT_W'(ch - CHAR_SPACE) : '0;
            end else begin
                line_pos++;
                if (line_is_data) begin
                    if (!group_bad && ch >= CHAR_SPACE && ch <= CHAR_HIGH)
                        group_bits |= ACC_W'(6'(ch - CHAR_SPACE)) << (6 * group_slot);
                    else
                        group_bad = 1'b1;
                    if (group_slot == 2'd3)
                        drain_group();
                    else
                        group_slot++;
                end
            end
            if (step_results > 0) begin
                last_r = decoded_q[decoded_q.size()-1];
                last_r.run_last = 1'b1;
                decoded_q[decoded_q.size()-1] = last_r;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_char(input logic [7:0] ch, input logic eot);
        text_item_t it;
        it.ch  = ch;
        it.eot = eot;
        pending_chars.push_back(it);
        chars_queued++;
    endtask

    // any byte but newline
    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 254));
        if (c >= CHAR_NEWLINE)
            c++;
        return c;
    endfunction

    // digit character, invalid below space or above 96 with the given odds
    function automatic logic [7:0] digit_char(input int bad_pct);
        logic [7:0] c;
        if ($urandom_range(0, 99) < bad_pct) begin
            if ($urandom_range(0, 1) == 0) begin
                c = 8'($urandom_range(0, 30));
                if (c >= CHAR_NEWLINE)
                    c++;
            end else begin
                c = 8'($urandom_range(CHAR_HIGH + 1, 255));
            end
        end else begin
            c = 8'($urandom_range(CHAR_SPACE, CHAR_HIGH));
        end
        return c;
    endfunction

    task automatic push_data_line(input int count, input int n_digits, input int bad_pct);
        push_char(8'(CHAR_SPACE + count), 1'b0);
        for (int i = 0; i < n_digits; i++)
            push_char(digit_char(bad_pct), 1'b0);
    endtask

    // one text of random lines closed by end of text
    task automatic queue_random_text();
        int n_lines;
        int kind;
        int count;
        int n_digits;
        int bad_pct;
        logic [7:0] first;
        n_lines = $urandom_range(1, 3);
        texts_queued++;
        for (int i = 0; i < n_lines; i++) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                // skipped line with a non-count first character
                do first = noise_char();
                while (first >= CHAR_SPACE + 8'd1 && first <= CHAR_SPACE + MAX_LINE_BYTES);
                push_char(first, 1'b0);
                n_digits = $urandom_range(0, 10);
                for (int j = 0; j < n_digits; j++)
                    push_char(noise_char(), 1'b0);
            end else if (kind == 1) begin
                // length around the line limit
                push_data_line($urandom_range(1, MAX_LINE_BYTES), $urandom_range(118, 130), 5);
            end else if (kind != 2) begin
                count    = ($urandom_range(0, 5) == 0) ? $urandom_range(1, MAX_LINE_BYTES)
                                                       : $urandom_range(1, 9);
                n_digits = 4 * ((count + 2) / 3);
                if ($urandom_range(0, 4) == 0)
                    n_digits = $urandom_range(0, n_digits + 8);
                bad_pct  = ($urandom_range(0, 3) == 0) ? 15 : 0;
                push_data_line(count, n_digits, bad_pct);
            end
            if (i < n_lines - 1 || $urandom_range(0, 3) != 0)
                push_char(CHAR_NEWLINE, 1'b0);
        end
        push_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic queue_directed();
        // end of text with nothing before it
        push_char(8'hA5, 1'b1);
        // count of one, all-ones digits
        push_data_line(1, 4, 0);
        for (int i = 0; i < 4; i++)
            pending_chars[pending_chars.size()-1-i].ch = 8'd95;
        push_char(CHAR_NEWLINE, 1'b0);
        // empty line
        push_char(CHAR_NEWLINE, 1'b0);
        // invalid digits at both borders break the group
        push_char(CHAR_SPACE + 8'd3, 1'b0);
        push_char(CHAR_SPACE, 1'b0);
        push_char(8'd31, 1'b0);
        push_char(8'd97, 1'b0);
        push_char(CHAR_HIGH, 1'b0);
        push_char(CHAR_NEWLINE, 1'b0);
        // skipped line
        push_char(CHAR_SPACE + MAX_LINE_BYTES + 8'd1, 1'b0);
        push_char(8'd255, 1'b0);
        push_char(CHAR_NEWLINE, 1'b0);
        // largest count with one group: zero padding up to the count
        push_char(CHAR_SPACE + MAX_LINE_BYTES, 1'b0);
        push_char(8'd64, 1'b0);
        push_char(8'd128, 1'b0);
        push_char(8'd65, 1'b0);
        push_char(8'd66, 1'b0);
        push_char(CHAR_NEWLINE, 1'b0);
        // count of one with two groups: excess bytes dropped, then a partial
        // group closed by end of text
        push_data_line(1, 8, 0);
        push_char(CHAR_NEWLINE, 1'b0);
        push_data_line(4, 2, 0);
        push_char(CHAR_NEWLINE, 1'b1);
        // one character past the line limit, then ignored input
        push_data_line(MAX_LINE_BYTES, MAX_LINE_CHARS, 0);
        push_char(CHAR_NEWLINE, 1'b0);
        push_char(8'd70, 1'b0);
        push_char(8'd0, 1'b1);
    endtask

    // wait until every character went in and every result came out
    task automatic wait_quiet();
        do @(negedge aclk);
        while (pending_chars.size() != 0 || chars_offered != chars_taken ||
               decoded_q.size() != 0);
        @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: inputs change on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            // a new character only once the previous one was taken
            if (chars_offered == chars_taken) begin
                if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_char = pending_chars.pop_front();
                    s_tdata  <= next_char.ch;
                    s_tlast  <= next_char.eot;
                    s_tvalid <= 1'b1;
                    chars_offered++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: both channels sampled on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            // output transaction against the oldest expectation
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual byte %0h user %0h",
                             $time, m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    check_field("out_byte", decoded_q[0].out_byte, m_tdata);
                    check_field("byte_valid", decoded_q[0].byte_valid, m_tuser[TUSER_BYTE_VALID]);
                    check_field("line_error", decoded_q[0].line_error, m_tuser[TUSER_LINE_ERROR]);
                    check_field("text_done", decoded_q[0].text_done, m_tuser[TUSER_TEXT_DONE]);
                    check_field("run_last", decoded_q[0].run_last, m_tlast);
                    void'(decoded_q.pop_front());
                end
                bytes_checked++;
            end
            // accepted character feeds the model
            if (s_tvalid && s_tready) begin
                decode_char(s_tdata, s_tlast);
                chars_taken++;
            end
            // watchdog on cycles with no transaction at all
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                    $display("tb_uudecode_stream_top: errors");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        queue_directed();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // sender idles now and then, receiver mostly stalls
        send_idle_pct = 37;
        recv_idle_pct = 88;
        chars_queued  = 0;
        while (chars_queued < PHASE_CHARS)
            queue_random_text();
        wait_quiet();

        // swapped idling
        send_idle_pct = 88;
        recv_idle_pct = 37;
        chars_queued  = 0;
        while (chars_queued < PHASE_CHARS)
            queue_random_text();
        wait_quiet();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        chars_queued  = 0;
        while (chars_queued < PHASE_CHARS)
            queue_random_text();
        wait_quiet();

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (decoded_q.size() != 0) begin
            $display("%0t: %0d expected transactions never arrived", $time, decoded_q.size());
            mismatches++;
        end
        $display("run covered %0d characters in %0d random texts plus directed text,",
                 chars_taken, texts_queued);
        $display("and checked %0d output transactions, %0d mismatches",
                 bytes_checked, mismatches);
        if (mismatches == 0)
            $display("tb_uudecode_stream_top: clean");
        else
            $display("tb_uudecode_stream_top: errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/uud_pkg.sv
design/uud_engine.sv
design/uudecode_stream_top.sv
test/tb_uudecode_stream_top.sv
